>>> rtl/rtnp_pkg.sv
package rtnp_pkg;

  // divider word width
  localparam int DIV_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // header defaults and time constants
  localparam logic [15:0] DEF_LENGTH    = 16'd4;
  localparam logic [3:0]  DEF_OCTAVE    = 4'd4;
  localparam logic [15:0] DEF_BPM       = 16'd90;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [15:0] TICK_MS       = 16'd10;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_KEY_D = 8'h64;
  localparam logic [7:0] CH_KEY_O = 8'h6f;
  localparam logic [7:0] CH_KEY_B = 8'h62;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_BAR   = 8'h7c;

  // note codes
  localparam logic [3:0] NOTE_PAUSE = 4'd0;
  localparam logic [3:0] NOTE_C     = 4'd1;
  localparam logic [3:0] NOTE_D     = 4'd3;
  localparam logic [3:0] NOTE_E     = 4'd5;
  localparam logic [3:0] NOTE_F     = 4'd6;
  localparam logic [3:0] NOTE_G     = 4'd8;
  localparam logic [3:0] NOTE_A     = 4'd10;
  localparam logic [3:0] NOTE_B     = 4'd12;

  typedef enum logic [3:0] {
    PH_HDR_D = 4'd0,
    PH_D_EQ  = 4'd1,
    PH_D_NUM = 4'd2,
    PH_HDR_O = 4'd3,
    PH_O_EQ  = 4'd4,
    PH_O_VAL = 4'd5,
    PH_O_SEP = 4'd6,
    PH_HDR_B = 4'd7,
    PH_B_EQ  = 4'd8,
    PH_B_NUM = 4'd9,
    PH_LEN   = 4'd10,
    PH_SHARP = 4'd11,
    PH_DOT   = 4'd12,
    PH_OCT   = 4'd13,
    PH_SEP   = 4'd14,
    PH_DONE  = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_TAKE,
    SQ_TEMPO1,
    SQ_TEMPO2,
    SQ_DUR,
    SQ_END
  } seq_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       final_req;
  } txt_t;

  typedef struct packed {
    logic [3:0]  note;
    logic [3:0]  octave;
    logic [15:0] duration_ticks;
    logic        melody_end;
    logic        run_last;
  } evt_t;

  // divider control and status
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  // letter to note code, anything unknown is a pause
  function automatic logic [3:0] letter_code(input logic [7:0] c);
    logic [3:0] code;
    case (c)
      8'h43, 8'h63: code = NOTE_C;
      8'h44, 8'h64: code = NOTE_D;
      8'h45, 8'h65: code = NOTE_E;
      8'h46, 8'h66: code = NOTE_F;
      8'h47, 8'h67: code = NOTE_G;
      8'h41, 8'h61: code = NOTE_A;
      8'h42, 8'h62: code = NOTE_B;
      default:      code = NOTE_PAUSE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/rtnp_div.sv
module rtnp_div (
  input  logic              clk,
  input  logic              rst,
  input  rtnp_pkg::div_req_t req,
  output rtnp_pkg::div_rsp_t rsp
);
  import rtnp_pkg::*;

  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_W:0]       part;
  logic [DIV_W+1:0]     trial;
  logic                 qbit;

  // one quotient bit per cycle, restoring
  assign part  = {rem, dvd[DIV_W-1]};
  assign trial = {1'b0, part} - {2'b00, dvs};
  assign qbit  = ~trial[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift registers for dividend/quotient and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], qbit};
      rem <= qbit ? trial[DIV_W-1:0] : part[DIV_W-1:0];
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

>>> rtl/rtnp_core.sv
module rtnp_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  rtnp_pkg::txt_t item,
  output logic           idle,
  output logic           res_valid,
  input  logic           res_ready,
  output rtnp_pkg::evt_t res
);
  import rtnp_pkg::*;

  seq_t        seq, seq_next;
  phase_t      phase, phase_next;
  logic [15:0] dflt_len, dflt_len_next;
  logic [3:0]  dflt_oct, dflt_oct_next;
  logic [15:0] whole_ticks, whole_ticks_next;
  logic [15:0] acc, acc_next;
  logic [3:0]  pnote, pnote_next;
  logic [3:0]  poct, poct_next;
  logic        pdot, pdot_next;
  logic [7:0]  c, c_next;
  logic        fin, fin_next;
  logic        retake, retake_next;
  logic        final_flag, final_flag_next;
  evt_t        hold, hold_next;
  logic        hold_valid, hold_valid_next;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [7:0]  dig;
  logic        is_dig;
  logic [15:0] acc_mac;
  logic [15:0] len_sel;
  logic [15:0] dur_sum;
  logic        do_emit;
  logic        do_tempo;
  logic [15:0] tempo_bpm;
  logic        tempo_retake;
  logic        need_final;

  rtnp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // digit helpers, accumulator times ten plus digit wraps at 16 bits
  assign dig     = c - CH_ZERO;
  assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign acc_mac = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {8'd0, dig};

  // note length, never zero
  always_comb begin
    len_sel = (acc != 16'd0) ? acc : dflt_len;
    if (len_sel == 16'd0) begin
      len_sel = 16'd1;
    end
  end

  // dotted adds half the duration
  assign dur_sum = div_rsp.quotient + (pdot ? {1'b0, div_rsp.quotient[15:1]} : 16'd0);

  assign need_final = fin && (phase inside {[PH_SHARP:PH_DONE]});

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= SQ_IDLE;
      phase       <= PH_HDR_D;
      dflt_len    <= DEF_LENGTH;
      dflt_oct    <= DEF_OCTAVE;
      whole_ticks <= '0;
      acc         <= '0;
      pnote       <= '0;
      poct        <= '0;
      pdot        <= 1'b0;
      retake      <= 1'b0;
      final_flag  <= 1'b0;
      hold_valid  <= 1'b0;
    end else begin
      seq         <= seq_next;
      phase       <= phase_next;
      dflt_len    <= dflt_len_next;
      dflt_oct    <= dflt_oct_next;
      whole_ticks <= whole_ticks_next;
      acc         <= acc_next;
      pnote       <= pnote_next;
      poct        <= poct_next;
      pdot        <= pdot_next;
      retake      <= retake_next;
      final_flag  <= final_flag_next;
      hold_valid  <= hold_valid_next;
    end
  end

  // item and held result payload
  always_ff @(posedge clk) begin
    c    <= c_next;
    fin  <= fin_next;
    hold <= hold_next;
  end

  // parse sequencer: one parse step per cycle while no division or output push is pending, divisions on the shared unit
  always_comb begin
    seq_next         = seq;
    phase_next       = phase;
    dflt_len_next    = dflt_len;
    dflt_oct_next    = dflt_oct;
    whole_ticks_next = whole_ticks;
    acc_next         = acc;
    pnote_next       = pnote;
    poct_next        = poct;
    pdot_next        = pdot;
    c_next           = c;
    fin_next         = fin;
    retake_next      = retake;
    final_flag_next  = final_flag;
    hold_next        = hold;
    hold_valid_next  = hold_valid;
    div_req.start    = 1'b0;
    div_req.dividend = whole_ticks;
    div_req.divisor  = len_sel;
    res_valid        = 1'b0;
    res              = hold;
    idle             = (seq == SQ_IDLE);
    do_emit          = 1'b0;
    do_tempo         = 1'b0;
    tempo_bpm        = DEF_BPM;
    tempo_retake     = 1'b0;

    case (seq)
      SQ_IDLE: begin
        if (accept) begin
          c_next   = item.ch;
          fin_next = item.final_req;
          seq_next = SQ_TAKE;
          if (item.first) begin
            phase_next       = PH_HDR_D;
            dflt_len_next    = DEF_LENGTH;
            dflt_oct_next    = DEF_OCTAVE;
            whole_ticks_next = '0;
            acc_next         = '0;
            pnote_next       = '0;
            poct_next        = '0;
            pdot_next        = 1'b0;
          end
        end
      end

      SQ_TAKE: begin
        // stays in SQ_TAKE when the character is taken again
        seq_next = SQ_END;
        case (phase)
          PH_HDR_D: begin
            if (c == CH_KEY_D) begin
              acc_next   = '0;
              phase_next = PH_D_EQ;
            end else begin
              dflt_len_next = DEF_LENGTH;
              phase_next    = PH_HDR_O;
              seq_next      = SQ_TAKE;
            end
          end
          PH_D_EQ: phase_next = PH_D_NUM;
          PH_D_NUM: begin
            if (is_dig) begin
              acc_next = acc_mac;
            end else begin
              dflt_len_next = (acc != 16'd0) ? acc : DEF_LENGTH;
              acc_next      = '0;
              phase_next    = PH_HDR_O;
            end
          end
          PH_HDR_O: begin
            if (c == CH_KEY_O) begin
              phase_next = PH_O_EQ;
            end else begin
              dflt_oct_next = DEF_OCTAVE;
              phase_next    = PH_HDR_B;
              seq_next      = SQ_TAKE;
            end
          end
          PH_O_EQ: phase_next = PH_O_VAL;
          PH_O_VAL: begin
            dflt_oct_next = (dig inside {[8'd2:8'd7]}) ? dig[3:0] : DEF_OCTAVE;
            phase_next    = PH_O_SEP;
          end
          PH_O_SEP: phase_next = PH_HDR_B;
          PH_HDR_B: begin
            acc_next = '0;
            if (c == CH_KEY_B) begin
              phase_next = PH_B_EQ;
            end else begin
              do_tempo     = 1'b1;
              tempo_bpm    = DEF_BPM;
              tempo_retake = 1'b1;
            end
          end
          PH_B_EQ: phase_next = PH_B_NUM;
          PH_B_NUM: begin
            if (is_dig) begin
              acc_next = acc_mac;
            end else begin
              do_tempo  = 1'b1;
              tempo_bpm = (acc != 16'd0) ? acc : DEF_BPM;
            end
          end
          PH_LEN: begin
            if (is_dig) begin
              acc_next = acc_mac;
            end else begin
              pnote_next = letter_code(c);
              poct_next  = dflt_oct;
              pdot_next  = 1'b0;
              phase_next = PH_SHARP;
            end
          end
          PH_SHARP: begin
            phase_next = PH_DOT;
            if (c == CH_SHARP) begin
              if (pnote != NOTE_PAUSE) begin
                pnote_next = pnote + 4'd1;
              end
            end else begin
              seq_next = SQ_TAKE;
            end
          end
          PH_DOT: begin
            phase_next = PH_OCT;
            if (c == CH_DOT) begin
              pdot_next = 1'b1;
            end else begin
              seq_next = SQ_TAKE;
            end
          end
          PH_OCT: begin
            phase_next = PH_SEP;
            if (is_dig) begin
              poct_next = dig[3:0];
            end else begin
              seq_next = SQ_TAKE;
            end
          end
          PH_SEP: begin
            if ((c == CH_COMMA) || (c == CH_BAR)) begin
              phase_next = PH_DONE;
            end else begin
              do_emit = 1'b1;
            end
          end
          default: do_emit = 1'b1;
        endcase

        // header end: 60000 / bpm first
        if (do_tempo) begin
          div_req.start    = 1'b1;
          div_req.dividend = MS_PER_MINUTE;
          div_req.divisor  = tempo_bpm;
          retake_next      = tempo_retake;
          seq_next         = SQ_TEMPO1;
        end

        // note end: whole ticks over length
        if (do_emit) begin
          div_req.start   = 1'b1;
          final_flag_next = 1'b0;
          seq_next        = SQ_DUR;
        end
      end

      SQ_TEMPO1: begin
        // milliseconds per whole note, truncated to 16 bits, then to ticks
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {div_rsp.quotient[13:0], 2'b00};
          div_req.divisor  = TICK_MS;
          seq_next         = SQ_TEMPO2;
        end
      end

      SQ_TEMPO2: begin
        if (div_rsp.done) begin
          whole_ticks_next = div_rsp.quotient;
          acc_next         = '0;
          phase_next       = PH_LEN;
          seq_next         = retake ? SQ_TAKE : SQ_END;
        end
      end

      SQ_DUR: begin
        if (div_rsp.done) begin
          hold_next.note           = pnote;
          hold_next.octave         = poct;
          hold_next.duration_ticks = dur_sum;
          hold_next.melody_end     = final_flag || (c == CH_NUL);
          hold_next.run_last       = 1'b0;
          hold_valid_next          = 1'b1;
          acc_next                 = '0;
          phase_next               = PH_LEN;
          final_flag_next          = 1'b0;
          if (final_flag || (c == CH_NUL)) begin
            seq_next = SQ_END;
          end else begin
            seq_next = SQ_TAKE;
          end
        end
      end

      SQ_END: begin
        if (need_final) begin
          // flush an earlier note of this transaction before the last one
          if (hold_valid) begin
            res_valid = 1'b1;
            if (res_ready) begin
              hold_valid_next = 1'b0;
            end
          end else begin
            div_req.start   = 1'b1;
            final_flag_next = 1'b1;
            seq_next        = SQ_DUR;
          end
        end else begin
          if (fin && (phase == PH_LEN)) begin
            acc_next = '0;
          end
          if (hold_valid) begin
            res_valid      = 1'b1;
            res.run_last   = 1'b1;
            res.melody_end = hold.melody_end || fin;
            if (res_ready) begin
              hold_valid_next = 1'b0;
              seq_next        = SQ_IDLE;
            end
          end else begin
            seq_next = SQ_IDLE;
          end
        end
      end

      default: seq_next = SQ_IDLE;
    endcase
  end

  // no result is left behind when the parser goes idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_IDLE) |-> !hold_valid)
    else $error("held result while idle");

  // divider results arrive only while waiting for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> ((seq == SQ_TEMPO1) || (seq == SQ_TEMPO2) || (seq == SQ_DUR)))
    else $error("divider finished outside a wait state");

  // the divider is never restarted while running
  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a pushed result leaves the hold register on the next cycle
  a_push_clears: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> !hold_valid)
    else $error("hold register not released after push");

endmodule

>>> rtl/ringtone_text_note_parser_top.sv
// Ringtone text note parser.
// Input channel txt (txt_valid / txt_stall) carries one text character with
// the first and final_req marks; a transaction is taken when txt_valid is high
// and txt_stall is low. Output channel evt (evt_valid / evt_stall) carries note
// events; each input transaction gives zero, one or two events, the last one
// marked run_last.
// Flow: one character at a time. A character runs through its internal
// parse steps in order. A note end runs one 16-bit division on the shared
// bit-serial divider; the end of the header runs two divisions (tempo to
// milliseconds, then to ticks). The divider retires one quotient bit per
// cycle. txt_stall stays high until every event of the current transaction
// has been loaded into the output register.
// Reset clears the parser to the header state with default length 4, default
// octave 4 and zero whole-note ticks; no clearing pass is needed.
// When the receiver stalls, evt holds its value and the parser waits with the
// next event; one event can wait in the output register while the parser
// works on the following one.
module ringtone_text_note_parser_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           txt_valid,
  output logic           txt_stall,
  input  rtnp_pkg::txt_t txt,
  output logic           evt_valid,
  input  logic           evt_stall,
  output rtnp_pkg::evt_t evt
);
  import rtnp_pkg::*;

  logic idle;
  logic res_valid;
  logic res_ready;
  evt_t res;

  rtnp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (txt_valid && idle),
    .item      (txt),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign txt_stall = !idle;

  // output register, refilled in the cycle it is taken
  assign res_ready = !evt_valid || !evt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (res_ready) begin
      evt_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      evt <= res;
    end
  end

endmodule
